// ----- design/gmcp_pkg.sv -----
// ----------------------------------------------------------------------------
// gmcp_pkg
// Shared types and constants for the grid min-cost path block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gmcp_pkg;

  localparam int MAX_DIM     = 32;
  localparam int POS_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = 6;
  localparam int COST_W      = 16;
  localparam int SUM_W       = 22;
  localparam int MARK_ADDR_W = 2 * POS_W;
  localparam int STACK_DEPTH = 2 * MAX_DIM - 2;
  localparam int STK_W       = $clog2(STACK_DEPTH + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    MARK_START = 2'd0,
    MARK_LEFT  = 2'd1,
    MARK_UP    = 2'd2,
    MARK_DIAG  = 2'd3
  } mark_t;

  localparam logic [1:0] MOVE_RIGHT = 2'd0;
  localparam logic [1:0] MOVE_DOWN  = 2'd1;
  localparam logic [1:0] MOVE_DIAG  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic cell_step;    // take one cell
    logic restart;      // clear run position
    logic tb_start;     // load trace position from last cell
    logic tb_rd;        // issue mark read at trace position
    logic tb_step;      // evaluate read mark
    logic pop;          // move stack pointer down one
  } gmcp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_cell;    // current cell is the last of the grid
    logic tb_done;      // trace walk has stopped
    logic stk_empty;    // no moves left to emit
    logic stk_one;      // exactly one move left to emit
  } gmcp_sts_t;

endpackage

// ----- design/gmcp_datapath.sv -----
// ----------------------------------------------------------------------------
// gmcp_datapath
// Running-cost row buffer, mark memory, trace walk and move stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmcp_datapath import gmcp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gmcp_cmd_t               cmd,
  output gmcp_sts_t               sts,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [DIM_W-1:0]        cfg_val,
  input  logic signed [COST_W-1:0] cell_cost,
  output logic signed [SUM_W-1:0] total_cost,
  output logic [1:0]              top_move
);

  logic [DIM_W-1:0] rows_r, cols_r;
  logic [POS_W-1:0] rows_m1, cols_m1;
  logic [POS_W-1:0] row_r, col_r;
  logic signed [SUM_W-1:0] left_r, diag_r, total_r;
  logic signed [SUM_W-1:0] row_costs [MAX_DIM];
  logic [1:0] marks [MAX_DIM*MAX_DIM];
  logic [1:0] stack [STACK_DEPTH];
  logic [STK_W-1:0] sp_r;
  logic [POS_W-1:0] tr_r, tq_r;
  logic [1:0] mark_q_r;
  logic tb_done_r;

  // effective dimension minus one: 0 acts as 1, above MAX_DIM clamps
  function automatic logic [POS_W-1:0] dim_m1(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] t;
    if (v == '0) t = '0;
    else if (v > DIM_W'(MAX_DIM)) t = DIM_W'(MAX_DIM - 1);
    else t = v - DIM_W'(1);
    return t[POS_W-1:0];
  endfunction

  assign rows_m1 = dim_m1(rows_r);
  assign cols_m1 = dim_m1(cols_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(1);
      cols_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROWS: rows_r <= cfg_val;
        REG_COLS: cols_r <= cfg_val;
        default: ;
      endcase
    end
  end

  // cell recurrence
  logic signed [SUM_W-1:0] up, best, d;
  logic [1:0] mark;
  logic signed [SUM_W-1:0] c_ext;
  assign c_ext = SUM_W'(cell_cost);
  assign up    = row_costs[col_r];

  always_comb begin
    if (row_r == '0 && col_r == '0) begin
      best = '0; mark = MARK_START;
    end else if (row_r == '0) begin
      best = left_r; mark = MARK_LEFT;
    end else if (col_r == '0) begin
      best = up; mark = MARK_UP;
    end else if (up <= diag_r && up <= left_r) begin
      best = up; mark = MARK_UP;
    end else if (diag_r <= left_r) begin
      best = diag_r; mark = MARK_DIAG;
    end else begin
      best = left_r; mark = MARK_LEFT;
    end
  end
  assign d = best + c_ext;

  // position and neighbor costs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0; col_r <= '0; left_r <= '0; diag_r <= '0;
    end else if (cmd.restart || cfg_we) begin
      row_r <= '0; col_r <= '0; left_r <= '0; diag_r <= '0;
    end else if (cmd.cell_step) begin
      diag_r <= up;
      if (col_r != cols_m1) begin
        col_r  <= col_r + POS_W'(1);
        left_r <= d;
      end else begin
        col_r  <= '0;
        row_r  <= row_r + POS_W'(1);
        left_r <= '0;
      end
    end
  end

  // row buffer and total
  always_ff @(posedge clk) begin
    if (cmd.cell_step) begin
      row_costs[col_r] <= d;
      total_r          <= d;
    end
  end
  assign total_cost = total_r;

  // mark memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.cell_step) marks[{row_r, col_r}] <= mark;
    if (cmd.tb_rd)     mark_q_r <= marks[{tr_r, tq_r}];
  end

  // trace walk and move stack
  logic done_now;
  logic [1:0] push_mv;
  always_comb begin
    done_now = 1'b0;
    push_mv  = MOVE_RIGHT;
    if (sp_r == STK_W'(STACK_DEPTH)) done_now = 1'b1;
    else begin
      case (mark_q_r)
        MARK_LEFT: begin
          push_mv = MOVE_RIGHT; done_now = (tq_r == '0);
        end
        MARK_UP: begin
          push_mv = MOVE_DOWN; done_now = (tr_r == '0);
        end
        MARK_DIAG: begin
          push_mv = MOVE_DIAG; done_now = (tr_r == '0) || (tq_r == '0);
        end
        default: done_now = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0; tb_done_r <= 1'b0; tr_r <= '0; tq_r <= '0;
    end else if (cmd.tb_start) begin
      sp_r <= '0; tb_done_r <= 1'b0; tr_r <= rows_m1; tq_r <= cols_m1;
    end else if (cmd.tb_step) begin
      if (done_now) tb_done_r <= 1'b1;
      else begin
        sp_r <= sp_r + STK_W'(1);
        if (mark_q_r == MARK_LEFT || mark_q_r == MARK_DIAG) tq_r <= tq_r - POS_W'(1);
        if (mark_q_r == MARK_UP   || mark_q_r == MARK_DIAG) tr_r <= tr_r - POS_W'(1);
      end
    end else if (cmd.pop) begin
      sp_r <= sp_r - STK_W'(1);
    end
  end

  // stack read address follows the pointer's next value on a pop, so the
  // registered top is ready in the cycle after a pop; otherwise it reads the current top
  logic [STK_W-1:0] rd_idx;
  logic [1:0] top_q_r;
  assign rd_idx = cmd.pop ? sp_r - STK_W'(2) : sp_r - STK_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.tb_step && !done_now) stack[sp_r] <= push_mv;
    if (rd_idx < STK_W'(STACK_DEPTH)) top_q_r <= stack[rd_idx];
  end

  assign top_move = top_q_r;

  always_comb begin
    sts.last_cell = (row_r == rows_m1) && (col_r == cols_m1);
    sts.tb_done   = tb_done_r;
    sts.stk_empty = (sp_r == '0);
    sts.stk_one   = (sp_r == STK_W'(1));
  end

  // stack never exceeds its depth
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= STK_W'(STACK_DEPTH))
    else $error("move stack overflow");
  // a pop never happens on an empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> sp_r != '0)
    else $error("pop on empty stack");
  // cell step and trace never overlap
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.cell_step && (cmd.tb_step || cmd.tb_rd)))
    else $error("cell step during trace");

endmodule

// ----- design/gmcp_ctrl.sv -----
// ----------------------------------------------------------------------------
// gmcp_ctrl
// Sequencer: cell intake, trace walk and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmcp_ctrl import gmcp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic      out_kind,
  output logic      out_last,
  output logic      cost_sel,
  output gmcp_cmd_t cmd,
  input  gmcp_sts_t sts
);

  typedef enum logic [2:0] {
    S_CELL, S_RD, S_EVAL, S_COST, S_MOVE
  } state_t;

  state_t state_r, state_nxt;
  logic in_acc, out_acc;

  assign in_tready = (state_r == S_CELL);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_COST) || (state_r == S_MOVE);
  assign out_acc   = out_tvalid && out_tready;
  assign cost_sel  = (state_r == S_COST);
  assign out_kind  = (state_r == S_MOVE);
  // in S_MOVE the stack is non-empty; last when one entry remains
  assign out_last  = (state_r == S_COST) ? sts.stk_empty : sts.stk_one;

  // commands
  always_comb begin
    cmd = '0;
    cmd.cell_step = in_acc;
    cmd.tb_start  = in_acc && sts.last_cell;
    cmd.tb_rd     = (state_r == S_RD);
    cmd.tb_step   = (state_r == S_EVAL);
    cmd.pop       = (state_r == S_MOVE) && out_acc;
    cmd.restart   = (state_r == S_COST || state_r == S_MOVE) && out_acc && out_last;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CELL: if (in_acc && sts.last_cell) state_nxt = S_RD;
      S_RD:   state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_RD;
      S_COST: if (out_acc) state_nxt = sts.stk_empty ? S_CELL : S_MOVE;
      S_MOVE: if (out_acc && out_last) state_nxt = S_CELL;
      default: state_nxt = S_CELL;
    endcase
    if (state_r == S_RD && sts.tb_done) state_nxt = S_COST;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CELL;
    else        state_r <= state_nxt;
  end

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken during emission");
  a_trace_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tb_start |=> state_r == S_RD)
    else $error("trace did not start");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

endmodule

// ----- design/grid_min_cost_path_traceback.sv -----
// ----------------------------------------------------------------------------
// grid_min_cost_path_traceback
// Minimum-cost grid path with right, down and diagonal moves and traceback.
// ----------------------------------------------------------------------------
// Usage:
//   Write grid_rows (index 0) and grid_cols (index 1) on the cfg channel while
//   idle; any write restarts the run. Cells arrive row-major on the in_ channel,
//   one beat per cycle. After the last cell the block stops taking beats, walks
//   the direction marks back via the mark memory read port, reading and then
//   evaluating one mark per move until the walk stops, then sends the total cost
//   beat followed by one beat per move from start to end; tlast marks the
//   final beat of the run. out_tvalid holds while out_tready is low; the block
//   waits. Reset sets both dimensions to 1 and restarts the run; stores need no
//   clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_min_cost_path_traceback import gmcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [COST_W-1:0]     in_tdata,    // [15:0] cell_cost
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [21:0] path_cost, [23:22] move_dir
  output logic                  out_tuser,   // [0] result_kind
  output logic                  out_tlast    // last_result
);

  gmcp_cmd_t cmd;
  gmcp_sts_t sts;
  logic cost_sel, kind;
  logic signed [SUM_W-1:0] total;
  logic [1:0] top_move;

  assign cfg_ready = 1'b1;

  gmcp_ctrl u_ctrl (
    .clk, .rst_n,
    .in_tvalid (in_tvalid), .in_tready (in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_kind  (kind), .out_last(out_tlast), .cost_sel(cost_sel),
    .cmd, .sts
  );

  gmcp_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_we (cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .cell_cost (in_tdata), .total_cost(total), .top_move(top_move)
  );

  assign out_tuser = kind;
  assign out_tdata = cost_sel ? {2'b00, total} : {top_move, {SUM_W{1'b0}}};

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Bench for the grid min-cost path block: drives cost grids of several shapes
// and predicts the total cost and the traceback move beats of every run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import gmcp_pkg::*;

  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic              kind;
    logic [SUM_W-1:0]  cost;
    logic [1:0]        dir;
    logic              last;
  } path_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [DIM_W-1:0]      cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [COST_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  always #2 clk = ~clk;

  grid_min_cost_path_traceback u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  // predictor state
  logic [DIM_W-1:0]        rows_reg = DIM_W'(1), cols_reg = DIM_W'(1);
  logic signed [SUM_W-1:0] run_cost [MAX_DIM];
  logic signed [SUM_W-1:0] left_sum, diag_sum;
  mark_t                   marks [MAX_DIM][MAX_DIM];
  int                      cur_row, cur_col;
  path_beat_t              pending_beats [$];

  int  fail_cnt = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;

  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // one cell into the predictor; pushes any beats it causes
  task automatic predict_cell(logic [COST_W-1:0] raw);
    int nr, nc, tr, tq;
    logic signed [SUM_W-1:0] c, up, d;
    mark_t m;
    logic [1:0] moves [$];
    path_beat_t b;
    nr = clamp_dim(rows_reg);
    nc = clamp_dim(cols_reg);
    c = SUM_W'($signed(raw));
    if (cur_row >= nr || cur_col >= nc) begin
      cur_row = 0; cur_col = 0; left_sum = 0; diag_sum = 0;
    end
    up = run_cost[cur_col];
    if (cur_row == 0 && cur_col == 0) begin
      d = c; m = MARK_START;
    end else if (cur_row == 0) begin
      d = left_sum + c; m = MARK_LEFT;
    end else if (cur_col == 0) begin
      d = up + c; m = MARK_UP;
    end else if (up <= diag_sum && up <= left_sum) begin
      d = up + c; m = MARK_UP;
    end else if (diag_sum <= left_sum) begin
      d = diag_sum + c; m = MARK_DIAG;
    end else begin
      d = left_sum + c; m = MARK_LEFT;
    end
    diag_sum = up;
    run_cost[cur_col] = d;
    left_sum = d;
    marks[cur_row][cur_col] = m;
    if (cur_col + 1 < nc) begin
      cur_col++;
      return;
    end
    if (cur_row + 1 < nr) begin
      cur_col = 0; cur_row++; left_sum = 0;
      return;
    end
    // last cell: walk marks back
    tr = cur_row; tq = cur_col;
    while (moves.size() < STACK_DEPTH) begin
      m = marks[tr][tq];
      if (m == MARK_START) break;
      if (m == MARK_LEFT) begin
        if (tq == 0) break;
        moves.push_front(MOVE_RIGHT); tq--;
      end else if (m == MARK_UP) begin
        if (tr == 0) break;
        moves.push_front(MOVE_DOWN); tr--;
      end else begin
        if (tr == 0 || tq == 0) break;
        moves.push_front(MOVE_DIAG); tr--; tq--;
      end
    end
    b = '{kind: 1'b0, cost: d, dir: 2'd0, last: moves.size() == 0};
    pending_beats.push_back(b);
    foreach (moves[i]) begin
      b = '{kind: 1'b1, cost: '0, dir: moves[i], last: i == moves.size() - 1};
      pending_beats.push_back(b);
    end
    cur_row = 0; cur_col = 0; left_sum = 0; diag_sum = 0;
  endtask

  function automatic bit maybe_idle();
    return idle_on && ($urandom_range(99) < 17);
  endfunction

  // send one cell beat; tvalid stays high after the accepting edge
  task automatic send_cell(logic [COST_W-1:0] v);
    while (maybe_idle()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_cell(v);
  endtask

  // wait for drain, then write one register
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ROWS) rows_reg = val;
    else rows_reg = rows_reg;
    if (idx == REG_COLS) cols_reg = val;
    cur_row = 0; cur_col = 0; left_sum = 0; diag_sum = 0;
  endtask

  task automatic set_shape(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
    write_reg(REG_ROWS, r);
    write_reg(REG_COLS, c);
  endtask

  task automatic run_grid(int r, int c, int mode);
    for (int i = 0; i < r * c; i++) begin
      case (mode)
        0: send_cell(COST_W'($urandom));
        1: send_cell(COST_W'($urandom_range(4)));
        2: send_cell(16'h7fff);
        3: send_cell(16'h8000);
        default: send_cell(16'h0000);
      endcase
    end
    in_tvalid <= 1'b0;
  endtask

  // directed: extremes, degenerate shapes, ties
  task automatic test_directed();
    run_grid(1, 1, 2);
    run_grid(1, 1, 3);
    set_shape(2, 2);
    run_grid(2, 2, 4);
    run_grid(2, 2, 0);
    set_shape(1, 4);
    run_grid(1, 4, 3);
    set_shape(3, 1);
    run_grid(3, 1, 2);
    set_shape(0, 63);
    run_grid(1, 1, 4);
    run_grid(1, 1, 1);
    set_shape(2, 0);
    run_grid(2, 1, 0);
  endtask

  // tallest and widest grids, once with extreme costs
  task automatic test_large();
    set_shape(32, 3);
    run_grid(32, 3, 3);
    set_shape(2, 40);
    run_grid(2, 32, 0);
  endtask

  // restart mid-run, through writes to both the rows and the cols index
  task automatic test_restart();
    set_shape(3, 3);
    run_grid(1, 4, 0);
    write_reg(REG_ROWS, 3);
    run_grid(3, 3, 0);
    run_grid(2, 1, 1);
    write_reg(REG_COLS, 3);
    run_grid(3, 3, 1);
  endtask

  // random small shapes
  task automatic test_random();
    int r, c;
    for (int k = 0; k < 20; k++) begin
      if (k == 10) idle_on = 1'b0;
      if (k == 15) idle_on = 1'b1;
      r = $urandom_range(1, 4);
      c = $urandom_range(1, 4);
      set_shape(r, c);
      run_grid(r, c, $urandom_range(3) == 0 ? 1 : 0);
    end
  endtask

  // receiver side: stall at random, check each beat
  always @(posedge clk) begin
    path_beat_t got, want;
    if (rst_n) begin
      out_tready <= !maybe_idle();
      if (out_tvalid && out_tready) begin
        got = '{kind: out_tuser, cost: out_tdata[21:0],
                dir: out_tdata[23:22], last: out_tlast};
        if (pending_beats.size() == 0) begin
          $error("unexpected beat kind=%0d cost=%0d", got.kind, got.cost);
          fail_cnt++;
        end else begin
          want = pending_beats.pop_front();
          if (got.kind !== want.kind) begin
            $error("result_kind exp %0d got %0d", want.kind, got.kind); fail_cnt++;
          end
          if (got.cost !== want.cost) begin
            $error("path_cost exp %0d got %0d", $signed(want.cost), $signed(got.cost));
            fail_cnt++;
          end
          if (got.dir !== want.dir) begin
            $error("move_dir exp %0d got %0d", want.dir, got.dir); fail_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last_result exp %0d got %0d", want.last, got.last); fail_cnt++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cur_row = 0; cur_col = 0; left_sum = 0; diag_sum = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_large();
    test_restart();
    test_random();
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0 && pending_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
